>>> rtl/tip_pkg.sv
package tip_pkg;

  localparam int GRID_SIZE  = 256;
  localparam int VAL_W      = 16;
  localparam int CRD_W      = 24;
  localparam int STEP_W     = 23;
  localparam int CELL_W     = 8;
  localparam int TETRA_W    = 12;
  localparam int CFG_W      = 24;
  localparam int IDX_W      = CELL_W + 1;
  localparam int PROD_W     = IDX_W + STEP_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int DIFF_W     = CRD_W + 1;
  localparam int DV_W       = VAL_W + 1;
  localparam int QUO_W      = CRD_W;
  localparam int NUM_W      = DV_W + QUO_W;
  localparam int DIV_STAGES = 4;
  localparam int DIV_STEPS  = QUO_W / DIV_STAGES;
  localparam int SIDE_LEN   = 3 + DIV_STAGES;

  localparam logic [2:0] REG_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_ORIGIN_X  = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Y  = 3'd2;
  localparam logic [2:0] REG_ORIGIN_Z  = 3'd3;
  localparam logic [2:0] REG_STEP_X    = 3'd4;
  localparam logic [2:0] REG_STEP_Y    = 3'd5;
  localparam logic [2:0] REG_STEP_Z    = 3'd6;
  localparam logic [2:0] REG_TETRA     = 3'd7;

  localparam logic [STEP_W-1:0]  STEP_RESET  = STEP_W'(4096);
  localparam logic [TETRA_W-1:0] TETRA_RESET = TETRA_W'(4000);

  localparam logic signed [CRD_W-1:0] CRD_MAX = {1'b0, {(CRD_W-1){1'b1}}};
  localparam logic signed [CRD_W-1:0] CRD_MIN = {1'b1, {(CRD_W-1){1'b0}}};

  typedef struct packed {
    logic [CELL_W-1:0]       cell_x;
    logic [CELL_W-1:0]       cell_y;
    logic [CELL_W-1:0]       cell_z;
    logic signed [VAL_W-1:0] value_a;
    logic signed [VAL_W-1:0] value_b;
    logic signed [VAL_W-1:0] value_c;
    logic signed [VAL_W-1:0] value_d;
  } in_item_t;

  typedef struct packed {
    logic signed [CRD_W-1:0] first_x;
    logic signed [CRD_W-1:0] first_y;
    logic signed [CRD_W-1:0] first_z;
    logic signed [CRD_W-1:0] second_x;
    logic signed [CRD_W-1:0] second_y;
    logic signed [CRD_W-1:0] second_z;
    logic signed [CRD_W-1:0] third_x;
    logic signed [CRD_W-1:0] third_y;
    logic signed [CRD_W-1:0] third_z;
    logic                    last_triangle;
  } out_item_t;

  typedef struct packed {
    logic [1:0]      ntri;
    logic [5:0][3:0] edges;
  } case_t;

  typedef struct packed {
    logic [DV_W-1:0]  rem;
    logic [QUO_W-1:0] qn;
  } div_st_t;

  typedef struct packed {
    logic                       last;
    logic [2:0]                 early;
    logic [2:0][2:0]            neg;
    logic [2:0][2:0][CRD_W-1:0] base;
  } side_t;

  function automatic case_t mk_case(logic [1:0] n, logic [3:0] a0, logic [3:0] a1,
                                    logic [3:0] a2, logic [3:0] b0, logic [3:0] b1,
                                    logic [3:0] b2);
    case_t r;
    r.ntri     = n;
    r.edges[0] = a0;
    r.edges[1] = a1;
    r.edges[2] = a2;
    r.edges[3] = b0;
    r.edges[4] = b1;
    r.edges[5] = b2;
    return r;
  endfunction

  // edge code: from corner in [3:2], to corner in [1:0]
  function automatic case_t case_lookup(logic [3:0] code);
    case_t r;
    case (code) inside
      4'd1, 4'd14: r = mk_case(2'd1, 4'd1, 4'd2, 4'd3, 4'd0, 4'd0, 4'd0);
      4'd2, 4'd13: r = mk_case(2'd1, 4'd4, 4'd7, 4'd6, 4'd0, 4'd0, 4'd0);
      4'd3, 4'd12: r = mk_case(2'd2, 4'd3, 4'd2, 4'd7, 4'd7, 4'd6, 4'd2);
      4'd4, 4'd11: r = mk_case(2'd1, 4'd8, 4'd9, 4'd11, 4'd0, 4'd0, 4'd0);
      4'd5, 4'd10: r = mk_case(2'd2, 4'd1, 4'd11, 4'd3, 4'd1, 4'd6, 4'd11);
      4'd6, 4'd9:  r = mk_case(2'd2, 4'd1, 4'd7, 4'd11, 4'd1, 4'd2, 4'd11);
      4'd7, 4'd8:  r = mk_case(2'd1, 4'd12, 4'd14, 4'd13, 4'd0, 4'd0, 4'd0);
      default:     r = mk_case(2'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0);
    endcase
    return r;
  endfunction

  // {dz, dy, dx}
  function automatic logic [2:0] corner_off(logic [2:0] n);
    logic [2:0] r;
    case (n)
      3'd0:    r = 3'b000;
      3'd1:    r = 3'b010;
      3'd2:    r = 3'b011;
      3'd3:    r = 3'b001;
      3'd4:    r = 3'b100;
      3'd5:    r = 3'b110;
      3'd6:    r = 3'b111;
      default: r = 3'b101;
    endcase
    return r;
  endfunction

  function automatic logic [CELL_W-1:0] clamp_cell(logic [CELL_W-1:0] c);
    if (int'(c) > GRID_SIZE - 1) begin
      return CELL_W'(GRID_SIZE - 1);
    end
    return c;
  endfunction

  function automatic logic signed [CRD_W-1:0] sat_crd(logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(CRD_MAX)) begin
      return CRD_MAX;
    end
    if (v < SUM_W'(CRD_MIN)) begin
      return CRD_MIN;
    end
    return v[CRD_W-1:0];
  endfunction

  function automatic div_st_t div_steps(div_st_t st, logic [DV_W-1:0] d);
    div_st_t       r;
    logic [DV_W:0] t;
    r = st;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t = {r.rem, r.qn[QUO_W-1]};
      if (t >= {1'b0, d}) begin
        r.rem = DV_W'(t - {1'b0, d});
        r.qn  = {r.qn[QUO_W-2:0], 1'b1};
      end else begin
        r.rem = t[DV_W-1:0];
        r.qn  = {r.qn[QUO_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

>>> rtl/tip_div.sv
module tip_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [tip_pkg::NUM_W-1:0]   num,
  input  logic [tip_pkg::DV_W-1:0]    den,
  output logic [tip_pkg::QUO_W-1:0]   quo
);
  import tip_pkg::*;

  div_st_t         st_r   [DIV_STAGES];
  div_st_t         st_nxt [DIV_STAGES];
  div_st_t         st_in;
  logic [DV_W-1:0] den_r  [DIV_STAGES-1];

  // remainder starts below den since the quotient fits QUO_W bits
  always_comb begin
    st_in.rem = num[NUM_W-1 -: DV_W];
    st_in.qn  = num[QUO_W-1:0];
    st_nxt[0] = div_steps(st_in, den);
    for (int s = 1; s < DIV_STAGES; s++) begin
      st_nxt[s] = div_steps(st_r[s-1], den_r[s-1]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      for (int s = 1; s < DIV_STAGES - 1; s++) begin
        den_r[s] <= den_r[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
        st_r[s] <= st_nxt[s];
      end
    end
  end

  assign quo = st_r[DIV_STAGES-1].qn;

endmodule

>>> rtl/tetrahedron_isosurface_polygonizer.sv
// channel | dir | handshake              | payload
// in      | in  | in_valid / in_ready    | in_data   (in_item_t)
// out     | out | out_valid / out_ready  | out_data  (out_item_t)
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// Triangles leave at one triangle per cycle while out_ready does not stall the pipeline.
// A cell with two triangles holds the corner stage for its second triangle; others do not hold it.
// The divider (4 stages, 6 quotient bits each) and the multiplier stages set the depth.
// rst_n is synchronous: clears valid bits and loads register defaults.
// A stall on out_ready freezes the whole pipeline; nothing is dropped.
module tetrahedron_isosurface_polygonizer (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  tip_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output tip_pkg::out_item_t  out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [tip_pkg::CFG_W-1:0] cfg_data
);
  import tip_pkg::*;

  logic signed [VAL_W-1:0] thr_r;
  logic signed [CRD_W-1:0] org_r [3];
  logic [STEP_W-1:0]       step_r [3];
  logic [TETRA_W-1:0]      tetra_r;

  logic adv, front_adv, c_done;

  logic                    a_v_r;
  in_item_t                a_r;
  logic                    b_v_r;
  logic [PROD_W-1:0]       b_prod_r [4][3];
  logic signed [VAL_W-1:0] b_val_r [4];
  logic [3:0]              b_code_r;
  logic                    c_v_r;
  logic                    c_tri_r;
  logic signed [CRD_W-1:0] c_pos_r [4][3];
  logic signed [VAL_W-1:0] c_val_r [4];
  logic [3:0]              c_code_r;
  case_t                   c_case;

  logic [PROD_W-1:0]       b_prod_nxt [4][3];
  logic signed [VAL_W-1:0] a_val [4];
  logic [3:0]              b_code_nxt;

  logic signed [DV_W-1:0]   d_dv_nxt [3];
  logic signed [DV_W-1:0]   d_den_nxt [3];
  logic signed [DIFF_W-1:0] d_diff_nxt [3][3];
  side_t                    d_side_nxt;
  logic signed [DV_W-1:0]   d_dv_r [3];
  logic signed [DV_W-1:0]   d_den_r [3];
  logic signed [DIFF_W-1:0] d_diff_r [3][3];

  logic [DV_W-1:0]  e_adv_r [3];
  logic [DV_W-1:0]  e_aden_r [3];
  logic [CRD_W-1:0] e_adiff_r [3][3];
  logic [NUM_W-1:0] f_num_r [3][3];
  logic [DV_W-1:0]  f_den_r [3];
  logic [QUO_W-1:0] quo [3][3];

  logic  v_r [SIDE_LEN];
  side_t side_r [SIDE_LEN];
  side_t e_side_nxt;

  logic signed [CRD_W-1:0] res [3][3];
  out_item_t               out_nxt;
  logic                    out_valid_r;
  out_item_t               out_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= '0;
      tetra_r <= TETRA_RESET;
      for (int k = 0; k < 3; k++) begin
        org_r[k]  <= '0;
        step_r[k] <= STEP_RESET;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_THRESHOLD: thr_r      <= cfg_data[VAL_W-1:0];
        REG_ORIGIN_X:  org_r[0]   <= cfg_data[CRD_W-1:0];
        REG_ORIGIN_Y:  org_r[1]   <= cfg_data[CRD_W-1:0];
        REG_ORIGIN_Z:  org_r[2]   <= cfg_data[CRD_W-1:0];
        REG_STEP_X:    step_r[0]  <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:    step_r[1]  <= cfg_data[STEP_W-1:0];
        REG_STEP_Z:    step_r[2]  <= cfg_data[STEP_W-1:0];
        REG_TETRA:     tetra_r    <= cfg_data[TETRA_W-1:0];
        default: ;
      endcase
    end
  end

  assign c_case    = case_lookup(c_code_r);
  assign c_done    = (c_case.ntri != 2'd2) || c_tri_r;
  assign adv       = !out_valid_r || out_ready;
  assign front_adv = adv && (!c_v_r || c_done);
  assign in_ready  = front_adv && rst_n;

  // stage B: corner index times step, inside code
  always_comb begin
    logic [CELL_W-1:0] cell_idx [3];
    logic [2:0]        off;
    logic [IDX_W-1:0]  idx;
    cell_idx[0] = clamp_cell(a_r.cell_x);
    cell_idx[1] = clamp_cell(a_r.cell_y);
    cell_idx[2] = clamp_cell(a_r.cell_z);
    a_val[0] = a_r.value_a;
    a_val[1] = a_r.value_b;
    a_val[2] = a_r.value_c;
    a_val[3] = a_r.value_d;
    for (int i = 0; i < 4; i++) begin
      off = corner_off(tetra_r[3*i +: 3]);
      for (int k = 0; k < 3; k++) begin
        idx = IDX_W'(cell_idx[k]) + IDX_W'(off[k]);
        b_prod_nxt[i][k] = PROD_W'(idx) * PROD_W'(step_r[k]);
      end
      b_code_nxt[i] = a_val[i] < thr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
      c_v_r   <= 1'b0;
      c_tri_r <= 1'b0;
    end else if (front_adv) begin
      a_v_r   <= in_valid;
      b_v_r   <= a_v_r;
      c_v_r   <= b_v_r;
      c_tri_r <= 1'b0;
    end else if (adv && c_v_r) begin
      c_tri_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (front_adv) begin
      a_r      <= in_data;
      b_prod_r <= b_prod_nxt;
      b_val_r  <= a_val;
      b_code_r <= b_code_nxt;
      c_val_r  <= b_val_r;
      c_code_r <= b_code_r;
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 3; k++) begin
          c_pos_r[i][k] <= sat_crd(SUM_W'(org_r[k]) + $signed(SUM_W'(b_prod_r[i][k])));
        end
      end
    end
  end

  // stage D: edge selection for the current triangle
  always_comb begin
    logic [2:0]              eidx;
    logic [3:0]              e;
    logic [1:0]              p, q;
    logic signed [VAL_W-1:0] vp, vq;
    logic                    use_q;
    d_side_nxt      = '0;
    d_side_nxt.last = c_case.ntri == (c_tri_r ? 2'd2 : 2'd1);
    for (int j = 0; j < 3; j++) begin
      eidx  = 3'(j) + (c_tri_r ? 3'd3 : 3'd0);
      e     = c_case.edges[eidx];
      p     = e[3:2];
      q     = e[1:0];
      vp    = c_val_r[p];
      vq    = c_val_r[q];
      use_q = (thr_r != vp) && (thr_r == vq);
      d_side_nxt.early[j] = (thr_r == vp) || (thr_r == vq) || (vp == vq);
      d_dv_nxt[j]  = DV_W'(thr_r) - DV_W'(vp);
      d_den_nxt[j] = DV_W'(vq) - DV_W'(vp);
      for (int k = 0; k < 3; k++) begin
        d_diff_nxt[j][k] = DIFF_W'(c_pos_r[q][k]) - DIFF_W'(c_pos_r[p][k]);
        d_side_nxt.base[j][k] = use_q ? c_pos_r[q][k] : c_pos_r[p][k];
      end
    end
  end

  always_comb begin
    e_side_nxt = side_r[0];
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        e_side_nxt.neg[j][k] = d_dv_r[j][DV_W-1] ^ d_den_r[j][DV_W-1]
                               ^ d_diff_r[j][k][DIFF_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SIDE_LEN; s++) begin
        v_r[s] <= 1'b0;
      end
    end else if (adv) begin
      v_r[0] <= c_v_r && (c_case.ntri != 2'd0);
      for (int s = 1; s < SIDE_LEN; s++) begin
        v_r[s] <= v_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side_r[0] <= d_side_nxt;
      side_r[1] <= e_side_nxt;
      for (int s = 2; s < SIDE_LEN; s++) begin
        side_r[s] <= side_r[s-1];
      end
      d_dv_r   <= d_dv_nxt;
      d_den_r  <= d_den_nxt;
      d_diff_r <= d_diff_nxt;
      for (int j = 0; j < 3; j++) begin
        e_adv_r[j]  <= d_dv_r[j][DV_W-1] ? DV_W'(-d_dv_r[j]) : DV_W'(d_dv_r[j]);
        e_aden_r[j] <= d_den_r[j][DV_W-1] ? DV_W'(-d_den_r[j]) : DV_W'(d_den_r[j]);
        f_den_r[j]  <= e_aden_r[j];
        for (int k = 0; k < 3; k++) begin
          e_adiff_r[j][k] <= d_diff_r[j][k][DIFF_W-1] ? CRD_W'(-d_diff_r[j][k])
                                                       : CRD_W'(d_diff_r[j][k]);
          f_num_r[j][k]   <= NUM_W'(e_adv_r[j]) * NUM_W'(e_adiff_r[j][k]);
        end
      end
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_vtx
    for (genvar k = 0; k < 3; k++) begin : g_axis
      tip_div u_div (
        .clk (clk),
        .en  (adv),
        .num (f_num_r[j][k]),
        .den (f_den_r[j]),
        .quo (quo[j][k])
      );
    end
  end

  // final stage: base plus signed quotient, or base alone on an early return
  always_comb begin
    logic signed [SUM_W-1:0] b, qv;
    for (int j = 0; j < 3; j++) begin
      for (int k = 0; k < 3; k++) begin
        b  = SUM_W'($signed(side_r[SIDE_LEN-1].base[j][k]));
        qv = $signed(SUM_W'(quo[j][k]));
        if (side_r[SIDE_LEN-1].early[j]) begin
          res[j][k] = side_r[SIDE_LEN-1].base[j][k];
        end else if (side_r[SIDE_LEN-1].neg[j][k]) begin
          res[j][k] = sat_crd(b - qv);
        end else begin
          res[j][k] = sat_crd(b + qv);
        end
      end
    end
    out_nxt.first_x       = res[0][0];
    out_nxt.first_y       = res[0][1];
    out_nxt.first_z       = res[0][2];
    out_nxt.second_x      = res[1][0];
    out_nxt.second_y      = res[1][1];
    out_nxt.second_z      = res[1][2];
    out_nxt.third_x       = res[2][0];
    out_nxt.third_y       = res[2][1];
    out_nxt.third_z       = res[2][2];
    out_nxt.last_triangle = side_r[SIDE_LEN-1].last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= v_r[SIDE_LEN-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_second_tri_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
    c_v_r && c_tri_r |-> c_case.ntri == 2'd2)
    else $error("second triangle selected for a cell without two");

  a_hold_for_second: assert property (@(posedge clk) disable iff (!rst_n)
    adv && c_v_r && !c_done |=> c_v_r && c_tri_r)
    else $error("corner stage did not hold for the second triangle");

  a_pair_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_data.last_triangle |=>
      out_valid && out_data.last_triangle)
    else $error("first triangle of a pair not followed by the last one");

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import tip_pkg::*;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  tetrahedron_isosurface_polygonizer DUT (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // shadow copy of the configuration registers
  logic signed [VAL_W-1:0] iso_level = '0;
  logic signed [CRD_W-1:0] grid_org [3] = '{'0, '0, '0};
  logic [STEP_W-1:0]       grid_step [3] = '{23'd4096, 23'd4096, 23'd4096};
  logic [TETRA_W-1:0]      corner_sel = 12'd4000;

  in_item_t  cell_queue [$];
  out_item_t triangle_queue [$];
  int        idle_pct = 0;
  int        stall_pct = 0;
  bit        hold_req = 0;
  int        hold_cnt = 0;
  int        quiet_cycles = 0;
  bit        failed = 0;

  // per triangle case: triangle total, then the edges as from*4+to
  int tri_cases [16][7] = '{
    '{0, 0, 0, 0, 0, 0, 0}, '{1, 1, 2, 3, 0, 0, 0}, '{1, 4, 7, 6, 0, 0, 0},
    '{2, 3, 2, 7, 7, 6, 2}, '{1, 8, 9, 11, 0, 0, 0}, '{2, 1, 11, 3, 1, 6, 11},
    '{2, 1, 7, 11, 1, 2, 11}, '{1, 12, 14, 13, 0, 0, 0}, '{1, 12, 14, 13, 0, 0, 0},
    '{2, 1, 7, 11, 1, 2, 11}, '{2, 1, 11, 3, 1, 6, 11}, '{1, 8, 9, 11, 0, 0, 0},
    '{2, 3, 2, 7, 7, 6, 2}, '{1, 4, 7, 6, 0, 0, 0}, '{1, 1, 2, 3, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0, 0}};

  // cube corner offsets {dx, dy, dz}
  logic [2:0] cube_offs [8] = '{3'b000, 3'b010, 3'b110, 3'b100,
                                3'b001, 3'b011, 3'b111, 3'b101};

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic polygonize(in_item_t c);
    longint    pos [4][3];
    longint    lvl [4];
    longint    thr;
    longint    vtx [3];
    longint    idx;
    int        code;
    int        ntri;
    int        p;
    int        q;
    out_item_t t;
    logic [7:0] cidx [3];
    logic [2:0] n;
    thr = iso_level;
    cidx = '{c.cell_x, c.cell_y, c.cell_z};
    lvl = '{c.value_a, c.value_b, c.value_c, c.value_d};
    code = 0;
    for (int i = 0; i < 4; i++) begin
      n = corner_sel[3*i +: 3];
      for (int k = 0; k < 3; k++) begin
        idx = longint'(cidx[k]) + cube_offs[n][2-k];
        pos[i][k] = clip24(longint'(grid_org[k]) + idx * longint'(grid_step[k]));
      end
      if (lvl[i] < thr) code |= 1 << i;
    end
    ntri = tri_cases[code][0];
    for (int tr = 0; tr < ntri; tr++) begin
      for (int v = 0; v < 3; v++) begin
        p = tri_cases[code][1 + 3*tr + v] >> 2;
        q = tri_cases[code][1 + 3*tr + v] & 3;
        for (int k = 0; k < 3; k++) begin
          if (thr == lvl[p] || (thr != lvl[q] && lvl[p] == lvl[q])) vtx[k] = pos[p][k];
          else if (thr == lvl[q]) vtx[k] = pos[q][k];
          else vtx[k] = clip24(pos[p][k] +
                               (thr - lvl[p]) * (pos[q][k] - pos[p][k]) / (lvl[q] - lvl[p]));
        end
        case (v)
          0: {t.first_x, t.first_y, t.first_z} = {24'(vtx[0]), 24'(vtx[1]), 24'(vtx[2])};
          1: {t.second_x, t.second_y, t.second_z} = {24'(vtx[0]), 24'(vtx[1]), 24'(vtx[2])};
          default: {t.third_x, t.third_y, t.third_z} = {24'(vtx[0]), 24'(vtx[1]), 24'(vtx[2])};
        endcase
      end
      t.last_triangle = (tr == ntri - 1);
      triangle_queue = {triangle_queue, t};
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (cell_queue.size() > 0 && $urandom_range(99) >= idle_pct) begin
        in_data  <= cell_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (hold_req && hold_cnt < 400) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready) polygonize(in_data);
    if (out_valid && out_ready) begin
      if (triangle_queue.size() == 0) begin
        $display("%0t unexpected triangle: expected none, actual %p", $time, out_data);
        failed = 1;
      end else begin
        if (out_data !== triangle_queue[0]) begin
          $display("%0t triangle error: expected %p, actual %p",
                   $time, triangle_queue[0], out_data);
          failed = 1;
        end
        void'(triangle_queue.pop_front());
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("tetrahedron_isosurface_polygonizer: mismatch");
      $finish;
    end
  end

  task automatic cfg_write(logic [2:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic configure(logic signed [15:0] thr, logic signed [23:0] ox,
                           logic signed [23:0] oy, logic signed [23:0] oz,
                           logic [22:0] sx, logic [22:0] sy, logic [22:0] sz,
                           logic [11:0] tet);
    cfg_write(REG_THRESHOLD, 24'(thr));
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_ORIGIN_Z, oz);
    cfg_write(REG_STEP_X, 24'(sx));
    cfg_write(REG_STEP_Y, 24'(sy));
    cfg_write(REG_STEP_Z, 24'(sz));
    cfg_write(REG_TETRA, 24'(tet));
    cfg_valid <= 1'b0;
    iso_level = thr;
    grid_org = '{ox, oy, oz};
    grid_step = '{sx, sy, sz};
    corner_sel = tet;
  endtask

  function automatic in_item_t random_cell();
    in_item_t c;
    int       v;
    c.value_a = 16'($urandom);
    c.value_b = 16'($urandom);
    c.value_c = 16'($urandom);
    c.value_d = 16'($urandom);
    {c.cell_x, c.cell_y, c.cell_z} = 24'($urandom);
    if ($urandom_range(3) == 0) begin
      v = int'(iso_level) + $urandom_range(6) - 3;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      case ($urandom_range(3))
        0: c.value_a = 16'(v);
        1: c.value_b = 16'(v);
        2: c.value_c = 16'(v);
        default: c.value_d = 16'(v);
      endcase
    end
    if ($urandom_range(1)) begin
      // values near the iso level so that many cases are hit
      c.value_a = iso_level + $signed(16'($urandom_range(512))) - 16'sd256;
      c.value_b = iso_level + $signed(16'($urandom_range(512))) - 16'sd256;
      c.value_c = iso_level + $signed(16'($urandom_range(512))) - 16'sd256;
      c.value_d = iso_level + $signed(16'($urandom_range(512))) - 16'sd256;
    end
    return c;
  endfunction

  task automatic run_phase(int n, int idle, int stall, bit hold);
    idle_pct = idle;
    stall_pct = stall;
    hold_req = hold;
    repeat (n) cell_queue = {cell_queue, random_cell()};
    while (cell_queue.size() > 0 || in_valid || triangle_queue.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  initial begin
    in_item_t c;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int code = 0; code < 16; code++) begin
      c = random_cell();
      c.value_a = code[0] ? -16'sd256 : 16'sd256;
      c.value_b = code[1] ? -16'sd1 : 16'sd0;
      c.value_c = code[2] ? -16'sd32768 : 16'sd32767;
      c.value_d = code[3] ? -16'sd77 : 16'sd0;
      cell_queue = {cell_queue, c};
    end
    c = '{8'd0, 8'd0, 8'd0, -16'sd32768, 16'sd32767, 16'sd0, -16'sd32768};
    cell_queue = {cell_queue, c};
    c = '{8'd255, 8'd255, 8'd255, 16'sd32767, -16'sd32768, 16'sd32767, 16'sd0};
    cell_queue = {cell_queue, c};
    c = '{8'd255, 8'd0, 8'd170, -16'sd5, -16'sd5, 16'sd5, 16'sd5};
    cell_queue = {cell_queue, c};
    run_phase(0, 0, 0, 0);
    run_phase(200, 0, 0, 0);

    configure(16'($urandom), 24'sh7fffff, 24'sh7ff000, 24'sh000100,
              23'h7fffff, 23'h7fffff, 23'($urandom), 12'($urandom));
    run_phase(200, 57, 0, 0);
    configure(-16'sd32768, -24'sh800000, -24'sh800000, -24'sh800000,
              23'd0, 23'd0, 23'd0, 12'd0);
    run_phase(60, 0, 57, 0);
    configure(16'sd32767, 24'($urandom), 24'($urandom), 24'($urandom),
              23'd1, 23'd4096, 23'($urandom_range(100000)), 12'hfff);
    run_phase(100, 34, 34, 0);
    configure(16'($urandom), -24'sd100000, 24'sd5000, 24'sd0,
              23'($urandom_range(200000)), 23'($urandom_range(200000)),
              23'($urandom_range(200000)), 12'($urandom));
    run_phase(200, 0, 0, 1);
    configure(16'($urandom_range(2000)) - 16'sd1000, 24'($urandom), 24'($urandom),
              24'($urandom), 23'($urandom), 23'($urandom), 23'($urandom), 12'($urandom));
    run_phase(200, 34, 34, 0);

    if (!failed) begin
      $display("tetrahedron_isosurface_polygonizer: match");
    end else begin
      $display("tetrahedron_isosurface_polygonizer: mismatch");
    end
    $finish;
  end

endmodule
